[design/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

`endif

[design/hpq_pkg.sv]
// Types and codes of the max-heap priority queue.
package hpq_pkg;

   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_EXTRACT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_EVAL,
      ST_DN_ROOT,
      ST_DN_RD,
      ST_DN_EVAL
   } state_type;

   typedef struct packed {
      logic [15:0] key;
      logic [15:0] entry_id;
      logic [7:0]  entry_type;
      logic [15:0] entry_count;
   } heap_entry_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] key;
      logic [15:0] entry_id;
      logic [7:0]  entry_type;
      logic [15:0] entry_count;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] out_key;
      logic [15:0] out_id;
      logic [7:0]  out_type;
      logic [15:0] out_count;
      logic [6:0]  fill_level;
   } rsp_type;

endpackage

[design/hpq_mem.sv]
// Heap entry memory: one write port, two registered read ports.
module hpq_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                    clock,
   input  logic [AW-1:0]           rd_addr_a,
   input  logic [AW-1:0]           rd_addr_b,
   output hpq_pkg::heap_entry_type rd_data_a,
   output hpq_pkg::heap_entry_type rd_data_b,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  hpq_pkg::heap_entry_type wr_data
);

   hpq_pkg::heap_entry_type mem [DEPTH];
   hpq_pkg::heap_entry_type rd_a_ff;
   hpq_pkg::heap_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[design/max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue.
//
// Requests enter on req_data when start is high and busy is low. cmd selects
// insert or extract of the maximum entry. Each request yields exactly one
// result on rsp_data, shown for one cycle with rsp_strobe high; the receiver
// cannot stall, so results are never held back.
// An insert opens a hole at the end and walks it up, moving each smaller
// parent down, and writes the entry where the walk stops; an extract
// returns the root and walks the last entry down from the root.
// Each level of a walk is a memory read state and then a compare/write
// state; a walk covers at most log2 CAPACITY levels. Overflow and empty
// results are shown in the cycle after the request. The memory
// read-compare-write loop sets the rate.
// busy is low in the cycle the result is shown, so a new request may be
// taken then. Reset empties the queue at once; no clearing pass is needed
// since only entries below the fill count are ever used.
`include "assert_macros.svh"

module max_heap_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hpq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output hpq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = IDX_W + 2;

   hpq_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   hpq_pkg::heap_entry_type mover_ff, mover_in;
   hpq_pkg::heap_entry_type res_ff, res_in;
   hpq_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   logic [IDX_W-1:0]        rd_addr_a, rd_addr_b, wr_addr;
   hpq_pkg::heap_entry_type rd_data_a, rd_data_b, wr_data;
   logic                    wr_en;

   logic [IDX_W-1:0]        idx_m1, parent_idx, last_idx;
   logic [CW-1:0]           left_idx, right_idx, count_cw;
   logic [CNT_W+6:0]        count_ext;
   logic                    left_ok, right_ok, pick_left, pick_right;
   hpq_pkg::heap_entry_type req_entry;

   hpq_mem #(
      .DEPTH(CAPACITY),
      .AW   (IDX_W)
   ) u_mem (
      .clock    (clock),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   assign req_entry.key         = req_data.key;
   assign req_entry.entry_id    = req_data.entry_id;
   assign req_entry.entry_type  = req_data.entry_type;
   assign req_entry.entry_count = req_data.entry_count;

   assign idx_m1     = idx_ff - IDX_W'(1);
   assign parent_idx = idx_m1 >> 1;
   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign left_idx   = {1'b0, idx_ff, 1'b1};
   assign right_idx  = left_idx + CW'(1);
   assign count_cw   = CW'(count_ff);
   assign count_ext  = {7'b0, count_ff};
   assign left_ok    = left_idx < count_cw;
   assign right_ok   = right_idx < count_cw;

   // Child selection for the downward walk; ties on key between the two children go to the lower id.
   always_comb begin
      pick_left  = 1'b0;
      pick_right = 1'b0;
      if (left_ok && (rd_data_a.key > mover_ff.key)) begin
         pick_left = 1'b1;
      end
      if (right_ok && (rd_data_b.key > (pick_left ? rd_data_a.key : mover_ff.key))) begin
         pick_left  = 1'b0;
         pick_right = 1'b1;
      end
      if (right_ok && (rd_data_a.key == rd_data_b.key) && (rd_data_a.key > mover_ff.key)) begin
         pick_left  = rd_data_a.entry_id < rd_data_b.entry_id;
         pick_right = !(rd_data_a.entry_id < rd_data_b.entry_id);
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      mover_in      = mover_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_addr_a     = '0;
      rd_addr_b     = last_idx;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = mover_ff;

      unique case (state_ff)
         hpq_pkg::ST_IDLE: begin
            if (start) begin
               if (req_data.cmd == hpq_pkg::CMD_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     rsp_strobe_in     = 1'b1;
                     rsp_in            = '0;
                     rsp_in.status     = hpq_pkg::STATUS_OVERFLOW;
                     rsp_in.fill_level = count_ext[6:0];
                  end else begin
                     mover_in = req_entry;
                     idx_in   = IDX_W'(count_ff);
                     count_in = count_ff + CNT_W'(1);
                     state_in = hpq_pkg::ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                     rsp_in.status = hpq_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = hpq_pkg::ST_DN_ROOT;
                  end
               end
            end
         end
         hpq_pkg::ST_UP_RD: begin
            rd_addr_a = parent_idx;
            if (idx_ff == '0) begin
               wr_en             = 1'b1;
               rsp_strobe_in     = 1'b1;
               rsp_in            = '0;
               rsp_in.status     = hpq_pkg::STATUS_OK;
               rsp_in.fill_level = count_ext[6:0];
               state_in          = hpq_pkg::ST_IDLE;
            end else begin
               state_in = hpq_pkg::ST_UP_EVAL;
            end
         end
         hpq_pkg::ST_UP_EVAL: begin
            wr_en = 1'b1;
            if (rd_data_a.key < mover_ff.key) begin
               wr_data  = rd_data_a;
               idx_in   = parent_idx;
               state_in = hpq_pkg::ST_UP_RD;
            end else begin
               rsp_strobe_in     = 1'b1;
               rsp_in            = '0;
               rsp_in.status     = hpq_pkg::STATUS_OK;
               rsp_in.fill_level = count_ext[6:0];
               state_in          = hpq_pkg::ST_IDLE;
            end
         end
         hpq_pkg::ST_DN_ROOT: begin
            res_in   = rd_data_a;
            mover_in = rd_data_b;
            idx_in   = '0;
            if (count_ff == '0) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = hpq_pkg::STATUS_OK;
               rsp_in.out_key    = rd_data_a.key;
               rsp_in.out_id     = rd_data_a.entry_id;
               rsp_in.out_type   = rd_data_a.entry_type;
               rsp_in.out_count  = rd_data_a.entry_count;
               rsp_in.fill_level = count_ext[6:0];
               state_in          = hpq_pkg::ST_IDLE;
            end else begin
               state_in = hpq_pkg::ST_DN_RD;
            end
         end
         hpq_pkg::ST_DN_RD: begin
            rd_addr_a = left_idx[IDX_W-1:0];
            rd_addr_b = right_idx[IDX_W-1:0];
            state_in  = hpq_pkg::ST_DN_EVAL;
         end
         hpq_pkg::ST_DN_EVAL: begin
            wr_en = 1'b1;
            if (pick_left) begin
               wr_data  = rd_data_a;
               idx_in   = left_idx[IDX_W-1:0];
               state_in = hpq_pkg::ST_DN_RD;
            end else if (pick_right) begin
               wr_data  = rd_data_b;
               idx_in   = right_idx[IDX_W-1:0];
               state_in = hpq_pkg::ST_DN_RD;
            end else begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = hpq_pkg::STATUS_OK;
               rsp_in.out_key    = res_ff.key;
               rsp_in.out_id     = res_ff.entry_id;
               rsp_in.out_type   = res_ff.entry_type;
               rsp_in.out_count  = res_ff.entry_count;
               rsp_in.fill_level = count_ext[6:0];
               state_in          = hpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hpq_pkg::ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      mover_ff <= mover_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != hpq_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY), "fill count above capacity")
   `ASSERT_IMPL(a_rsp_idle, rsp_strobe, !busy, "result shown while busy")
   `ASSERT_NEXT(a_req_progress, start && !busy, busy || rsp_strobe, "request dropped")
   `ASSERT_IMPL(a_wr_busy, wr_en, busy, "memory write while idle")
   `ASSERT_IMPL(a_ovf_full, rsp_strobe && (rsp_data.status == hpq_pkg::STATUS_OVERFLOW),
      count_ff == CNT_W'(CAPACITY), "overflow while not full")

endmodule
